// ===== sv/fpgt_pkg.sv =====
`default_nettype none

package fpgt_pkg;

	// Rule table geometry.
	localparam int unsigned SETS   = 7;
	localparam int unsigned DEPTH  = SETS * SETS;
	localparam int unsigned ADDR_W = 6;

	// Quantiser constants: membership span in Q16.16 and divider length.
	localparam logic [16:0] ONE_Q    = 17'd65536;
	localparam logic [19:0] Q_LIMIT  = 20'd393216;
	localparam int unsigned DIV_BITS = 20;

	// Blend pipeline: final run count, covering four table reads and the pipeline drain.
	localparam logic [2:0] RUN_LAST = 3'd5;

	typedef enum logic [2:0] {
		CFG_RANGE_MAX = 3'd0,
		CFG_RANGE_MIN = 3'd1,
		CFG_KP_MAX    = 3'd2,
		CFG_KP_MIN    = 3'd3,
		CFG_KI_MAX    = 3'd4,
		CFG_KI_MIN    = 3'd5,
		CFG_KD_MAX    = 3'd6,
		CFG_KD_MIN    = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TBL_KP = 2'd0,
		TBL_KI = 2'd1,
		TBL_KD = 2'd2
	} tbl_sel_t;

	typedef enum logic [2:0] {
		Q_IDLE,
		Q_PREP,
		Q_DIV,
		Q_MEMB,
		Q_DONE
	} q_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WR,
		B_RUN,
		B_FIN
	} b_state_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] measured_value;
		logic signed [31:0] target_value;
		logic signed [31:0] previous_error;
		logic [1:0]         table_select;
		logic [2:0]         rule_row;
		logic [2:0]         rule_column;
		logic signed [15:0] rule_value;
	} fpgt_in_t;

	typedef struct packed {
		logic signed [31:0] delta_kp;
		logic signed [31:0] delta_ki;
		logic signed [31:0] delta_kd;
		logic               load_done;
	} fpgt_out_t;

	// Memberships of one quantised value.
	typedef struct packed {
		logic        ok;
		logic [2:0]  k;
		logic [16:0] m0;
		logic [16:0] m1;
	} ms_t;

	// Word handed from the quantiser to the blender.
	typedef struct packed {
		logic               is_load;
		logic               load_ok;
		logic [1:0]         sel;
		logic [ADDR_W-1:0]  waddr;
		logic signed [15:0] wval;
		logic               ok;
		ms_t                me;
		ms_t                mc;
	} job_t;

	// Flat table address of row and column.
	function automatic logic [ADDR_W-1:0] rule_addr(input logic [2:0] row,
			input logic [2:0] col);
		rule_addr = ADDR_W'({row, 3'b000}) - ADDR_W'(row) + ADDR_W'(col);
	endfunction

	// Two adjacent triangular memberships of a quotient given as magnitude and sign.
	function automatic ms_t membership(input logic [19:0] quo, input logic neg);
		ms_t                r;
		logic signed [20:0] q;
		logic [20:0]        s;
		logic               top;
		logic [17:0]        t;
		q      = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		s      = 21'(q + 21'sd393216);
		top    = (s[19:17] == 3'd6);
		t      = {top, s[16:0]};
		r.ok   = (quo <= Q_LIMIT);
		r.k    = top ? 3'd5 : s[19:17];
		r.m1   = t[17:1];
		r.m0   = ONE_Q - t[17:1];
		return r;
	endfunction

	// Upper limit is tested first; with crossed limits a value above the maximum gives the maximum, any other the minimum.
	function automatic logic signed [31:0] clamp(input logic signed [31:0] x,
			input logic signed [31:0] hi, input logic signed [31:0] lo);
		if (x > hi) begin
			return hi;
		end else if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

endpackage

`default_nettype wire

// ===== sv/fpgt_ram.sv =====
`default_nettype none

module fpgt_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 49
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/fpgt_quant.sv =====
`default_nettype none

module fpgt_quant (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire fpgt_pkg::fpgt_in_t item,
	output logic                    item_take,
	input  wire logic signed [31:0] range_max,
	input  wire logic signed [31:0] range_min,
	output logic                    job_valid,
	input  wire logic               job_take,
	output fpgt_pkg::job_t          job
);

	fpgt_pkg::q_state_t state_q, state_d;
	fpgt_pkg::fpgt_in_t item_q;
	fpgt_pkg::job_t     job_q;

	logic [4:0]  cnt_q;
	logic [33:0] rem_e_q, rem_c_q;
	logic [19:0] low_e_q, low_c_q;
	logic [19:0] quo_e_q, quo_c_q;
	logic [32:0] rabs_q;
	logic        neg_e_q, neg_c_q, ovf_q;

	logic signed [32:0] err_w, rng_w;
	logic signed [33:0] derr_w;
	logic signed [51:0] num_e_w, num_c_w;
	logic [51:0]        mag_e_w, mag_c_w;
	logic [32:0]        rabs_w;
	logic               ovf_w;
	logic [33:0]        sh_e_w, sh_c_w;
	logic [34:0]        tr_e_w, tr_c_w;
	fpgt_pkg::ms_t      ms_e_w, ms_c_w;
	fpgt_pkg::job_t     load_job_w;
	fpgt_pkg::job_t     memb_job_w;

	// Error, error change and their scaled numerators; the range check
	// rejects any quotient of 2^20 or more before the divider starts.
	always_comb begin
		err_w   = 33'(item_q.target_value) - 33'(item_q.measured_value);
		derr_w  = 34'(err_w) - 34'(item_q.previous_error);
		num_e_w = (52'(err_w) <<< 18) + (52'(err_w) <<< 17);
		num_c_w = (52'(derr_w) <<< 17) + (52'(derr_w) <<< 16);
		rng_w   = 33'(range_max) - 33'(range_min);
		mag_e_w = num_e_w[51] ? (~num_e_w + 52'd1) : num_e_w;
		mag_c_w = num_c_w[51] ? (~num_c_w + 52'd1) : num_c_w;
		rabs_w  = rng_w[32] ? (~rng_w + 33'd1) : rng_w;
		ovf_w   = (rng_w == 33'sd0) || ({1'b0, mag_e_w[51:20]} >= rabs_w)
			|| ({1'b0, mag_c_w[51:20]} >= rabs_w);
	end

	// One restoring step per cycle for both quotients.
	always_comb begin
		sh_e_w = {rem_e_q[32:0], low_e_q[19]};
		sh_c_w = {rem_c_q[32:0], low_c_q[19]};
		tr_e_w = {1'b0, sh_e_w} - {2'b00, rabs_q};
		tr_c_w = {1'b0, sh_c_w} - {2'b00, rabs_q};
		ms_e_w = fpgt_pkg::membership(quo_e_q, neg_e_q);
		ms_c_w = fpgt_pkg::membership(quo_c_q, neg_c_q);
	end

	// A compute word carries only its memberships and their validity.
	always_comb begin
		memb_job_w    = '0;
		memb_job_w.ok = ms_e_w.ok && ms_c_w.ok && !ovf_q;
		memb_job_w.me = ms_e_w;
		memb_job_w.mc = ms_c_w;
	end

	// A load word needs only its address and validity worked out.
	always_comb begin
		load_job_w         = '0;
		load_job_w.is_load = 1'b1;
		load_job_w.load_ok = (item.table_select != 2'd3) && (item.rule_row != 3'd7)
			&& (item.rule_column != 3'd7);
		load_job_w.sel     = item.table_select;
		load_job_w.waddr   = fpgt_pkg::rule_addr(item.rule_row, item.rule_column);
		load_job_w.wval    = item.rule_value;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpgt_pkg::Q_IDLE: begin
				if (item_valid) begin
					state_d = item.action ? fpgt_pkg::Q_DONE : fpgt_pkg::Q_PREP;
				end
			end
			fpgt_pkg::Q_PREP: state_d = fpgt_pkg::Q_DIV;
			fpgt_pkg::Q_DIV: begin
				if (cnt_q == 5'(fpgt_pkg::DIV_BITS - 1)) begin
					state_d = fpgt_pkg::Q_MEMB;
				end
			end
			fpgt_pkg::Q_MEMB: state_d = fpgt_pkg::Q_DONE;
			fpgt_pkg::Q_DONE: begin
				if (job_take) begin
					state_d = fpgt_pkg::Q_IDLE;
				end
			end
			default: state_d = fpgt_pkg::Q_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		item_take = (state_q == fpgt_pkg::Q_IDLE);
		job_valid = (state_q == fpgt_pkg::Q_DONE);
		job       = job_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpgt_pkg::Q_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fpgt_pkg::Q_IDLE: begin
				if (item_valid) begin
					item_q <= item;
					job_q  <= load_job_w;
				end
			end
			fpgt_pkg::Q_PREP: begin
				rem_e_q <= {2'b00, mag_e_w[51:20]};
				rem_c_q <= {2'b00, mag_c_w[51:20]};
				low_e_q <= mag_e_w[19:0];
				low_c_q <= mag_c_w[19:0];
				rabs_q  <= rabs_w;
				neg_e_q <= num_e_w[51] ^ rng_w[32];
				neg_c_q <= num_c_w[51] ^ rng_w[32];
				ovf_q   <= ovf_w;
				cnt_q   <= '0;
			end
			fpgt_pkg::Q_DIV: begin
				rem_e_q <= tr_e_w[34] ? sh_e_w : tr_e_w[33:0];
				rem_c_q <= tr_c_w[34] ? sh_c_w : tr_c_w[33:0];
				quo_e_q <= {quo_e_q[18:0], ~tr_e_w[34]};
				quo_c_q <= {quo_c_q[18:0], ~tr_c_w[34]};
				low_e_q <= {low_e_q[18:0], 1'b0};
				low_c_q <= {low_c_q[18:0], 1'b0};
				cnt_q   <= cnt_q + 5'd1;
			end
			fpgt_pkg::Q_MEMB: begin
				job_q <= memb_job_w;
			end
			fpgt_pkg::Q_DONE: ;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/fpgt_blend.sv =====
`default_nettype none

module fpgt_blend (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 job_valid,
	input  wire fpgt_pkg::job_t       job,
	output logic                      job_take,
	input  wire logic signed [31:0]   kp_max,
	input  wire logic signed [31:0]   kp_min,
	input  wire logic signed [31:0]   ki_max,
	input  wire logic signed [31:0]   ki_min,
	input  wire logic signed [31:0]   kd_max,
	input  wire logic signed [31:0]   kd_min,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output fpgt_pkg::fpgt_out_t       result
);

	fpgt_pkg::b_state_t  state_q, state_d;
	fpgt_pkg::job_t      job_q;
	fpgt_pkg::fpgt_out_t out_q, fin_w;
	logic                out_valid_q, out_free_w;

	logic [2:0]                  cnt_q;
	logic [32:0]                 w_s1;
	logic signed [49:0]          prod_p_s2, prod_i_s2, prod_d_s2;
	logic signed [50:0]          acc_p_q, acc_i_q, acc_d_q;
	logic [fpgt_pkg::ADDR_W-1:0] raddr_w;
	logic [32:0]                 w_w;
	logic [2:0]                  ie_w, ic_w;
	logic [16:0]                 me_w, mc_w;
	logic [15:0]                 rd_p, rd_i, rd_d;
	logic                        wr_w;

	// Table memories, one per gain.
	assign wr_w = (state_q == fpgt_pkg::B_WR) && job_q.load_ok;

	fpgt_ram #(.WIDTH(16), .DEPTH(fpgt_pkg::DEPTH)) u_kp (
		.clk  (clk),
		.we   (wr_w && (job_q.sel == fpgt_pkg::TBL_KP)),
		.waddr(job_q.waddr),
		.wdata(job_q.wval),
		.raddr(raddr_w),
		.rdata(rd_p)
	);

	fpgt_ram #(.WIDTH(16), .DEPTH(fpgt_pkg::DEPTH)) u_ki (
		.clk  (clk),
		.we   (wr_w && (job_q.sel == fpgt_pkg::TBL_KI)),
		.waddr(job_q.waddr),
		.wdata(job_q.wval),
		.raddr(raddr_w),
		.rdata(rd_i)
	);

	fpgt_ram #(.WIDTH(16), .DEPTH(fpgt_pkg::DEPTH)) u_kd (
		.clk  (clk),
		.we   (wr_w && (job_q.sel == fpgt_pkg::TBL_KD)),
		.waddr(job_q.waddr),
		.wdata(job_q.wval),
		.raddr(raddr_w),
		.rdata(rd_d)
	);

	// Corner of the rule square visited in this cycle and its weight.
	always_comb begin
		ie_w    = job_q.me.k + {2'b00, cnt_q[1]};
		ic_w    = job_q.mc.k + {2'b00, cnt_q[0]};
		me_w    = cnt_q[1] ? job_q.me.m1 : job_q.me.m0;
		mc_w    = cnt_q[0] ? job_q.mc.m1 : job_q.mc.m0;
		raddr_w = fpgt_pkg::rule_addr(ie_w, ic_w);
		w_w     = 33'(me_w * mc_w);
	end

	// Floor to Q16.16 and clamp; a load word gives zero gains.
	always_comb begin
		fin_w = '0;
		if (job_q.is_load) begin
			fin_w.load_done = job_q.load_ok;
		end else begin
			fin_w.delta_kp = fpgt_pkg::clamp(32'($signed(acc_p_q[50:24])), kp_max, kp_min);
			fin_w.delta_ki = fpgt_pkg::clamp(32'($signed(acc_i_q[50:24])), ki_max, ki_min);
			fin_w.delta_kd = fpgt_pkg::clamp(32'($signed(acc_d_q[50:24])), kd_max, kd_min);
		end
		out_free_w = !out_valid_q || !result_stall;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpgt_pkg::B_IDLE: begin
				if (job_valid) begin
					if (job.is_load) begin
						state_d = fpgt_pkg::B_WR;
					end else if (job.ok) begin
						state_d = fpgt_pkg::B_RUN;
					end else begin
						state_d = fpgt_pkg::B_FIN;
					end
				end
			end
			fpgt_pkg::B_WR: state_d = fpgt_pkg::B_FIN;
			fpgt_pkg::B_RUN: begin
				if (cnt_q == fpgt_pkg::RUN_LAST) begin
					state_d = fpgt_pkg::B_FIN;
				end
			end
			fpgt_pkg::B_FIN: begin
				if (out_free_w) begin
					state_d = fpgt_pkg::B_IDLE;
				end
			end
			default: state_d = fpgt_pkg::B_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		job_take     = job_valid && (state_q == fpgt_pkg::B_IDLE);
		result_valid = out_valid_q;
		result       = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpgt_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == fpgt_pkg::B_FIN) && out_free_w) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read, weight, multiply, accumulate: one corner enters each cycle.
	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q   <= job;
			cnt_q   <= '0;
			acc_p_q <= '0;
			acc_i_q <= '0;
			acc_d_q <= '0;
		end else if (state_q == fpgt_pkg::B_RUN) begin
			cnt_q <= cnt_q + 3'd1;
			w_s1  <= w_w;
			if ((cnt_q != 3'd0) && (cnt_q != fpgt_pkg::RUN_LAST)) begin
				prod_p_s2 <= 50'($signed({1'b0, w_s1})) * 50'($signed(rd_p));
				prod_i_s2 <= 50'($signed({1'b0, w_s1})) * 50'($signed(rd_i));
				prod_d_s2 <= 50'($signed({1'b0, w_s1})) * 50'($signed(rd_d));
			end
			if (cnt_q >= 3'd2) begin
				acc_p_q <= acc_p_q + 51'(prod_p_s2);
				acc_i_q <= acc_i_q + 51'(prod_i_s2);
				acc_d_q <= acc_d_q + 51'(prod_d_s2);
			end
		end
		if ((state_q == fpgt_pkg::B_FIN) && out_free_w) begin
			out_q <= fin_w;
		end
	end

endmodule

`default_nettype wire

// ===== sv/fuzzy_pid_gain_tuner_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake                Payload
// item      in         item_valid / item_stall  fpgt_in_t
// result    out        result_valid / result_stall  fpgt_out_t
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A compute word passes the quantiser states PREP, DIV and MEMB (DIV is the
// restoring divider for both quotients), then the blender, which makes four table reads.
// A load word goes from IDLE to DONE in the quantiser and through WR to FIN in the blender.
// The quantiser takes a new word while the blender and output register work,
// so a compute word can be divided while the one before it is still blended.
// The result register holds a word under result_stall; reset clears all control.

module fuzzy_pid_gain_tuner_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire fpgt_pkg::fpgt_in_t  item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output fpgt_pkg::fpgt_out_t      result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	logic signed [31:0] range_max_q, range_min_q;
	logic signed [31:0] kp_max_q, kp_min_q, ki_max_q, ki_min_q, kd_max_q, kd_min_q;
	logic               item_take, job_valid, job_take;
	fpgt_pkg::job_t     job;

	assign cfg_ready  = 1'b1;
	assign item_stall = !item_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_max_q <= 32'sd65536;
			range_min_q <= 32'sd0;
			kp_max_q    <= 32'sd65536;
			kp_min_q    <= -32'sd65536;
			ki_max_q    <= 32'sd65536;
			ki_min_q    <= -32'sd65536;
			kd_max_q    <= 32'sd65536;
			kd_min_q    <= -32'sd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (fpgt_pkg::cfg_idx_t'(cfg_index))
				fpgt_pkg::CFG_RANGE_MAX: range_max_q <= cfg_data;
				fpgt_pkg::CFG_RANGE_MIN: range_min_q <= cfg_data;
				fpgt_pkg::CFG_KP_MAX:    kp_max_q    <= cfg_data;
				fpgt_pkg::CFG_KP_MIN:    kp_min_q    <= cfg_data;
				fpgt_pkg::CFG_KI_MAX:    ki_max_q    <= cfg_data;
				fpgt_pkg::CFG_KI_MIN:    ki_min_q    <= cfg_data;
				fpgt_pkg::CFG_KD_MAX:    kd_max_q    <= cfg_data;
				fpgt_pkg::CFG_KD_MIN:    kd_min_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	fpgt_quant u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take),
		.range_max (range_max_q),
		.range_min (range_min_q),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	fpgt_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (job),
		.job_take    (job_take),
		.kp_max      (kp_max_q),
		.kp_min      (kp_min_q),
		.ki_max      (ki_max_q),
		.ki_min      (ki_min_q),
		.kd_max      (kd_max_q),
		.kd_min      (kd_min_q),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

`ifndef SYNTHESIS
	// The quantiser holds one word, so it stalls right after taking one.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("quantiser took a second word while busy");

	// The blender only takes a word the quantiser offers.
	a_take_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid)
		else $error("blender took a word that was not offered");

	// A load acknowledgement carries zero gains.
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.load_done |->
			result.delta_kp == 32'sd0 && result.delta_ki == 32'sd0
			&& result.delta_kd == 32'sd0)
		else $error("load acknowledgement with non-zero gain");
`endif

endmodule

`default_nettype wire
